@@ src/ppm_pkg.sv @@
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared constants, character codes, result kinds and the queue entry type
// for the PPM P6 stream decoder.
// ----------------------------------------------------------------------------
package ppm_pkg;

    // Width of the parsed decimal fields and of the pixel count
    localparam int DIM_BITS      = 16;
    localparam int PROD_BITS     = 2 * DIM_BITS;
    localparam int ACC_BITS      = DIM_BITS + 4;
    localparam int OUT_DIM_BITS  = 16;
    localparam int PIXEL_BITS    = 32;

    // Queue between parser and result stage; depth must be a power of two
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = QPTR_BITS + 1;

    // Output stream packing
    localparam int RESULT_DATA_BITS = PIXEL_BITS + 2 * OUT_DIM_BITS + 1;
    localparam int TDATA_BITS       = ((RESULT_DATA_BITS + 7) / 8) * 8;
    localparam int TDATA_PAD_BITS   = TDATA_BITS - RESULT_DATA_BITS;

    // Configuration port
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic REG_IDX_HEADER_ONLY = 1'b0;

    // Result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_6    = 8'h36;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;

    localparam logic [7:0]          ALPHA_OPAQUE = 8'hFF;
    localparam logic [DIM_BITS-1:0] MAXVAL_REQ   = DIM_BITS'(255);

    // One queue entry: an optional pixel or header result, then an
    // optional final status
    typedef struct packed {
        logic                    has_main;
        logic                    main_is_header;
        logic [PIXEL_BITS-1:0]   pixel_word;
        logic [OUT_DIM_BITS-1:0] image_width;
        logic [OUT_DIM_BITS-1:0] image_height;
        logic                    has_end;
        logic                    end_status;
    } entry_t;

    typedef struct packed {
        logic [1:0]              result_kind;
        logic [PIXEL_BITS-1:0]   pixel_word;
        logic [OUT_DIM_BITS-1:0] image_width;
        logic [OUT_DIM_BITS-1:0] image_height;
        logic                    status_code;
        logic                    last_of_image;
    } result_t;

    function automatic logic [OUT_DIM_BITS-1:0] dim_out(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS+OUT_DIM_BITS-1:0] wide;
        wide = {{OUT_DIM_BITS{1'b0}}, v};
        return wide[OUT_DIM_BITS-1:0];
    endfunction

endpackage

@@ src/ppm_front.sv @@
// ----------------------------------------------------------------------------
// ppm_front
// Byte parser: checks the magic, accumulates width, height and maxval,
// tracks the raster and writes one queue entry per item that has results.
// ----------------------------------------------------------------------------
module ppm_front
    import ppm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,     // [7:0] data_byte
    input  logic         s_tuser,     // [0] byte_present
    input  logic         s_tlast,
    input  logic         header_only,
    input  logic         q_full,
    output logic         q_push,
    output entry_t       q_entry
);

    typedef enum logic [8:0] {
        PH_MAGIC1      = 9'b000000001,
        PH_MAGIC2      = 9'b000000010,
        PH_WIDTH       = 9'b000000100,
        PH_HEIGHT      = 9'b000001000,
        PH_MAXVAL      = 9'b000010000,
        PH_HDR_COMMENT = 9'b000100000,
        PH_PIXELS      = 9'b001000000,
        PH_DONE        = 9'b010000000,
        PH_ERROR       = 9'b100000000
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic                  comment_reg, comment_next;
    logic                  gap_reg, gap_next;
    logic                  digits_reg, digits_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [DIM_BITS-1:0]   maxval_reg, maxval_next;
    logic [PROD_BITS-1:0]  pixels_left_reg, pixels_left_next;
    logic [1:0]            channel_reg, channel_next;
    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [PROD_BITS-1:0]  product_reg;

    logic                  accept;
    logic [7:0]            c;
    logic                  c_ws;
    logic                  c_digit;
    logic [DIM_BITS-1:0]   acc_cur;
    logic [ACC_BITS-1:0]   acc_step;
    logic                  acc_over;
    logic                  acc_load;
    logic [DIM_BITS-1:0]   acc_value;
    logic                  finish;
    entry_t                entry;

    function automatic logic is_ws(input logic [7:0] b);
        return b inside {CHAR_SP, CHAR_TAB, CHAR_CR, CHAR_LF};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[CHAR_0:CHAR_9]};
    endfunction

    assign accept   = s_tvalid && !q_full;
    assign s_tready = !q_full;
    assign c        = s_tdata;
    assign c_ws     = is_ws(c);
    assign c_digit  = is_digit(c);

    always_comb
    begin
        case (phase_reg)
            PH_WIDTH:  acc_cur = width_reg;
            PH_HEIGHT: acc_cur = height_reg;
            default:   acc_cur = maxval_reg;
        endcase
    end

    // acc * 10 + digit; anything in the top four bits is past the field range
    assign acc_step = (ACC_BITS'(acc_cur) << 3) + (ACC_BITS'(acc_cur) << 1)
                    + ACC_BITS'(c[3:0]);
    assign acc_over = |acc_step[ACC_BITS-1:DIM_BITS];

    always_comb
    begin
        phase_next       = phase_reg;
        comment_next     = comment_reg;
        gap_next         = gap_reg;
        digits_next      = digits_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        maxval_next      = maxval_reg;
        pixels_left_next = pixels_left_reg;
        channel_next     = channel_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        acc_load         = 1'b0;
        acc_value        = acc_step[DIM_BITS-1:0];
        finish           = 1'b0;
        entry            = '0;

        if (accept && s_tuser)
        begin
            case (phase_reg)
                PH_MAGIC1:
                begin
                    phase_next = (c == CHAR_P) ? PH_MAGIC2 : PH_ERROR;
                end
                PH_MAGIC2:
                begin
                    if (c == CHAR_6)
                    begin
                        phase_next   = PH_WIDTH;
                        gap_next     = 1'b0;
                        digits_next  = 1'b0;
                        comment_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                    end
                end
                PH_WIDTH, PH_HEIGHT, PH_MAXVAL:
                begin
                    if (comment_reg)
                    begin
                        if (c == CHAR_LF)
                            comment_next = 1'b0;
                    end
                    else if (!digits_reg)
                    begin
                        if (c_ws)
                        begin
                            gap_next = 1'b1;
                        end
                        else if (c == CHAR_HASH)
                        begin
                            gap_next     = 1'b1;
                            comment_next = 1'b1;
                        end
                        else if (c_digit && gap_reg)
                        begin
                            digits_next = 1'b1;
                            acc_load    = 1'b1;
                            acc_value   = DIM_BITS'(c[3:0]);
                        end
                        else
                        begin
                            phase_next = PH_ERROR;
                        end
                    end
                    else if (c_digit)
                    begin
                        if (acc_over)
                            phase_next = PH_ERROR;
                        else
                            acc_load = 1'b1;
                    end
                    else if (!c_ws && c != CHAR_HASH)
                    begin
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        digits_next = 1'b0;
                        gap_next    = 1'b1;
                        if (phase_reg == PH_MAXVAL)
                        begin
                            if (c == CHAR_HASH)
                                phase_next = PH_HDR_COMMENT;
                            else
                                finish = 1'b1;
                        end
                        else
                        begin
                            comment_next = (c == CHAR_HASH);
                            phase_next   = (phase_reg == PH_WIDTH) ? PH_HEIGHT : PH_MAXVAL;
                        end
                    end
                end
                PH_HDR_COMMENT:
                begin
                    if (c == CHAR_LF)
                        finish = 1'b1;
                end
                PH_PIXELS:
                begin
                    case (channel_reg)
                        2'd0:
                        begin
                            red_next     = c;
                            channel_next = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next   = c;
                            channel_next = 2'd2;
                        end
                        default:
                        begin
                            channel_next     = 2'd0;
                            pixels_left_next = pixels_left_reg - PROD_BITS'(1);
                            if (pixels_left_reg == PROD_BITS'(1))
                                phase_next = PH_DONE;
                            if (!header_only)
                            begin
                                entry.has_main       = 1'b1;
                                entry.main_is_header = 1'b0;
                                entry.pixel_word     = {ALPHA_OPAQUE, red_reg, green_reg, c};
                            end
                        end
                    endcase
                end
                default:
                begin
                    // done or error: drop bytes until the end marker
                end
            endcase
        end

        if (acc_load)
        begin
            case (phase_reg)
                PH_WIDTH:  width_next  = acc_value;
                PH_HEIGHT: height_next = acc_value;
                default:   maxval_next = acc_value;
            endcase
        end

        // product_reg has settled: the height field closed at least two bytes ago
        if (finish)
        begin
            if (maxval_reg != MAXVAL_REQ)
            begin
                phase_next = PH_ERROR;
            end
            else
            begin
                pixels_left_next     = product_reg;
                channel_next         = 2'd0;
                phase_next           = (product_reg == '0) ? PH_DONE : PH_PIXELS;
                entry.has_main       = 1'b1;
                entry.main_is_header = 1'b1;
                entry.image_width    = dim_out(width_reg);
                entry.image_height   = dim_out(height_reg);
            end
        end

        if (accept && s_tlast)
        begin
            entry.has_end    = 1'b1;
            entry.end_status = (phase_next == PH_DONE) ? STATUS_OK : STATUS_INVALID;
            // rearm for the next image
            phase_next       = PH_MAGIC1;
            comment_next     = 1'b0;
            gap_next         = 1'b0;
            digits_next      = 1'b0;
            width_next       = '0;
            height_next      = '0;
            maxval_next      = '0;
            pixels_left_next = '0;
            channel_next     = 2'd0;
            red_next         = '0;
            green_next       = '0;
        end
    end

    assign q_push  = accept && (entry.has_main || entry.has_end);
    assign q_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_MAGIC1;
            comment_reg     <= 1'b0;
            gap_reg         <= 1'b0;
            digits_reg      <= 1'b0;
            width_reg       <= '0;
            height_reg      <= '0;
            maxval_reg      <= '0;
            pixels_left_reg <= '0;
            channel_reg     <= 2'd0;
            red_reg         <= '0;
            green_reg       <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            comment_reg     <= comment_next;
            gap_reg         <= gap_next;
            digits_reg      <= digits_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            maxval_reg      <= maxval_next;
            pixels_left_reg <= pixels_left_next;
            channel_reg     <= channel_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
        end
    end

    // Pixel count, registered from the field registers
    always_ff @(posedge clk)
    begin
        product_reg <= PROD_BITS'(width_reg) * PROD_BITS'(height_reg);
    end

endmodule

@@ src/ppm_queue.sv @@
// ----------------------------------------------------------------------------
// ppm_queue
// Short FIFO of result entries between the parser and the result stage.
// ----------------------------------------------------------------------------
module ppm_queue
    import ppm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output logic    full,
    output logic    head_valid,
    output entry_t  head
);

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ src/ppm_back.sv @@
// ----------------------------------------------------------------------------
// ppm_back
// Result stage: unpacks queue entries into single results and drives the
// registered output stream.
// ----------------------------------------------------------------------------
module ppm_back
    import ppm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  entry_t                 head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_BITS-1:0]  m_tdata,   // [31:0] pixel_word, [47:32] image_width,
                                              // [63:48] image_height, [64] status_code
    output logic [1:0]             m_tuser,   // [1:0] result_kind
    output logic                   m_tlast
);

    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;
    logic     pend_valid_reg, pend_valid_next;
    logic     pend_status_reg, pend_status_next;
    logic     load;

    function automatic result_t status_result(input logic st);
        result_t r;
        r               = '0;
        r.result_kind   = KIND_STATUS;
        r.status_code   = st;
        r.last_of_image = 1'b1;
        return r;
    endfunction

    assign load = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pop              = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                // status left over from a byte-and-end entry goes first
                out_valid_next  = 1'b1;
                out_next        = status_result(pend_status_reg);
                pend_valid_next = 1'b0;
            end
            else if (head_valid)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (head.has_main)
                begin
                    out_next              = '0;
                    out_next.result_kind  = head.main_is_header ? KIND_HEADER : KIND_PIXEL;
                    out_next.pixel_word   = head.pixel_word;
                    out_next.image_width  = head.image_width;
                    out_next.image_height = head.image_height;
                    pend_valid_next       = head.has_end;
                    pend_status_next      = head.end_status;
                end
                else
                begin
                    out_next = status_result(head.end_status);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg         <= out_next;
        pend_status_reg <= pend_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{TDATA_PAD_BITS{1'b0}}, out_reg.status_code, out_reg.image_height,
                       out_reg.image_width, out_reg.pixel_word};
    assign m_tuser  = out_reg.result_kind;
    assign m_tlast  = out_reg.last_of_image;

endmodule

@@ src/ppm_p6_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_stream_decoder
// PPM P6 byte stream decoder: header checks, raster packing into ARGB words,
// final status per image, APB register for header-only mode.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the queue is not full; a byte that
//   completes a pixel or header and also ends the file yields two results, the
//   result first and then its status.
// Path: the queue takes an item's entry at its transfer, and the output
//   register loads it from the queue head when free; a trailing status follows.
// Reset: rst_n is asynchronous, active low; clears the parser state, the queue
//   pointers, the output valid flags and header_only. No memory clearing pass.
// ----------------------------------------------------------------------------
module ppm_p6_stream_decoder
    import ppm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    output logic [APB_DATA_BITS-1:0]  prdata,
    output logic                      pready,
    // input bytes
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data_byte
    input  logic                      s_tuser,   // [0] byte_present
    input  logic                      s_tlast,
    // results
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [TDATA_BITS-1:0]     m_tdata,   // [31:0] pixel_word, [47:32] image_width,
                                                 // [63:48] image_height, [64] status_code
    output logic [1:0]                m_tuser,   // [1:0] result_kind
    output logic                      m_tlast
);

    logic    header_only_reg, header_only_next;
    logic    reg_hit;
    logic    q_full;
    logic    q_push;
    entry_t  q_entry;
    logic    q_pop;
    logic    q_head_valid;
    entry_t  q_head;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_BITS-1:2] == REG_IDX_HEADER_ONLY);

    always_comb
    begin
        header_only_next = header_only_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            header_only_next = pwdata[0];
    end

    assign prdata = reg_hit ? {{(APB_DATA_BITS-1){1'b0}}, header_only_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_only_reg <= 1'b0;
        else
            header_only_reg <= header_only_next;
    end

    ppm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .header_only (header_only_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    ppm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    ppm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // A full queue means the output register is holding a result
    assert property (@(posedge clk) disable iff (!rst_n) !s_tready |-> m_tvalid)
        else $error("queue full while output register empty");

    // Pop only when the output register can take the entry
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> (!m_tvalid || m_tready))
        else $error("queue popped while output stalled");

    // Only a status result closes an image
    assert property (@(posedge clk) disable iff (!rst_n)
                     (m_tvalid && m_tlast) |-> (m_tuser == KIND_STATUS))
        else $error("last flag on a non-status result");

    // An entry reaching the queue carries at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
                     q_push |-> (q_entry.has_main || q_entry.has_end))
        else $error("empty entry pushed");

endmodule
